// ----- rtl/scb_pkg.sv -----
package scb_pkg;

    localparam int SYM_BITS        = 8;
    localparam int PROB_BITS       = 16;
    localparam int LEN_BITS        = 5;
    localparam int WORD_BITS       = PROB_BITS + 1;
    localparam int SUM_BITS        = PROB_BITS + 1;
    localparam int MAX_SYMBOLS_DEF = 16;

    typedef struct packed {
        logic [SYM_BITS-1:0]  symbol;
        logic [PROB_BITS-1:0] probability;
        logic                 last_symbol;
    } t_in_item;

    typedef struct packed {
        logic [SYM_BITS-1:0]  out_symbol;
        logic [LEN_BITS-1:0]  code_length;
        logic [WORD_BITS-1:0] code_word;
        logic                 error_flag;
        logic                 last_code;
    } t_out_item;

    typedef struct packed {
        logic wr;
        logic start;
        logic scan_clear;
        logic cmp;
        logic emit;
        logic last;
    } t_ctrl_cmd;

    function automatic logic [LEN_BITS-1:0] bit_len(input logic [PROB_BITS-1:0] v);
        logic [LEN_BITS-1:0] n;
        n = '0;
        for (int k = 0; k < PROB_BITS; k++) begin
            if (v[k]) begin
                n = LEN_BITS'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- rtl/scb_ram.sv -----
module scb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/scb_ctrl.sv -----
module scb_ctrl
    import scb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_last_symbol,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output t_ctrl_cmd                      o_cmd,
    output logic [$clog2(MAX_SYMBOLS)-1:0] o_wr_idx,
    output logic [$clog2(MAX_SYMBOLS)-1:0] o_rd_idx,
    output logic [$clog2(MAX_SYMBOLS)-1:0] o_cmp_idx
);

    localparam int IW = $clog2(MAX_SYMBOLS);
    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_emit, n_emit;
    logic [IW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld, n_rd_vld;
    logic          r_out_valid, n_out_valid;
    logic          in_acc;
    logic          out_free;
    logic          last_out;
    t_ctrl_cmd     cmd;

    assign in_acc   = i_in_valid && (r_state == ST_LOAD);
    assign out_free = !r_out_valid || !i_out_stall;
    assign last_out = (r_emit + CW'(1)) == r_count;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_emit      = r_emit;
        n_addr      = r_addr;
        n_rd_vld    = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        cmd         = '0;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    cmd.wr  = 1'b1;
                    n_count = r_count + CW'(1);
                    if (i_last_symbol || (r_count + CW'(1)) == CW'(MAX_SYMBOLS)) begin
                        cmd.start      = 1'b1;
                        cmd.scan_clear = 1'b1;
                        n_state        = ST_SCAN;
                        n_addr         = '0;
                        n_emit         = '0;
                    end
                end
            end
            ST_SCAN: begin
                n_rd_vld = 1'b1;
                cmd.cmp  = r_rd_vld;
                if (CW'(r_addr) == r_count - CW'(1)) begin
                    n_state = ST_TAIL;
                end else begin
                    n_addr = r_addr + IW'(1);
                end
            end
            ST_TAIL: begin
                cmd.cmp = r_rd_vld;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.last    = last_out;
                    n_out_valid = 1'b1;
                    n_emit      = r_emit + CW'(1);
                    if (last_out) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        n_state        = ST_SCAN;
                        n_addr         = '0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_emit      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_emit      <= n_emit;
            r_addr      <= n_addr;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
    assign o_wr_idx    = r_count[IW-1:0];
    assign o_rd_idx    = r_addr;
    assign o_cmp_idx   = r_rd_idx;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over an untaken one");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SYMBOLS))
        else $error("entry count beyond store depth");

    a_close_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_symbol) |=> (o_in_stall && r_state == ST_SCAN))
        else $error("set not closed after last item");

    a_emit_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && !cmd.last) |=> (r_state == ST_SCAN && r_addr == '0))
        else $error("scan not restarted after result");

endmodule

// ----- rtl/scb_dp.sv -----
module scb_dp
    import scb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_ctrl_cmd                      i_cmd,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] i_wr_idx,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] i_rd_idx,
    input  logic [$clog2(MAX_SYMBOLS)-1:0] i_cmp_idx,
    input  t_in_item                       i_in_item,
    output t_out_item                      o_out_item
);

    localparam int IW = $clog2(MAX_SYMBOLS);
    localparam int EW = SYM_BITS + PROB_BITS;
    localparam logic [SUM_BITS:0] ONE = (SUM_BITS + 1)'(1) << PROB_BITS;

    logic [EW-1:0]        rd_data;
    logic [SYM_BITS-1:0]  rd_sym;
    logic [PROB_BITS-1:0] rd_prob;
    logic                 take;

    logic [MAX_SYMBOLS-1:0] r_done;
    logic                   r_best_vld;
    logic [PROB_BITS-1:0]   r_best_prob;
    logic [SYM_BITS-1:0]    r_best_sym;
    logic [IW-1:0]          r_best_idx;
    logic [SUM_BITS-1:0]    r_cum, n_cum;
    t_out_item              r_out, n_out;

    logic [LEN_BITS-1:0]  bl;
    logic                 err;
    logic [SUM_BITS:0]    sum_ext;

    scb_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SYMBOLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_wr_idx),
        .i_wdata ({i_in_item.symbol, i_in_item.probability}),
        .i_raddr (i_rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_sym  = rd_data[EW-1:PROB_BITS];
    assign rd_prob = rd_data[PROB_BITS-1:0];
    assign take    = i_cmd.cmp && !r_done[i_cmp_idx]
                     && (!r_best_vld || rd_prob > r_best_prob);

    always_comb begin
        bl      = bit_len(r_best_prob - PROB_BITS'(1));
        err     = (r_best_prob == '0) || r_cum[SUM_BITS-1];
        sum_ext = {1'b0, r_cum} + (SUM_BITS + 1)'(r_best_prob);
        n_cum   = (sum_ext > ONE) ? ONE[SUM_BITS-1:0] : sum_ext[SUM_BITS-1:0];

        n_out            = '0;
        n_out.out_symbol = r_best_sym;
        n_out.error_flag = err;
        n_out.last_code  = i_cmd.last;
        if (!err) begin
            n_out.code_length = LEN_BITS'(PROB_BITS + 1) - bl;
            n_out.code_word   = WORD_BITS'({r_cum[PROB_BITS-1:0], 1'b0} >> bl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= '0;
            r_best_vld <= 1'b0;
            r_cum      <= '0;
        end else begin
            if (i_cmd.start) begin
                r_done <= '0;
                r_cum  <= '0;
            end else if (i_cmd.emit) begin
                r_done[r_best_idx] <= 1'b1;
                r_cum              <= n_cum;
            end
            if (i_cmd.scan_clear) begin
                r_best_vld <= 1'b0;
            end else if (take) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_prob <= rd_prob;
            r_best_sym  <= rd_sym;
            r_best_idx  <= i_cmp_idx;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_item = r_out;

    a_emit_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_best_vld)
        else $error("result taken with no candidate");

    a_emit_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !i_cmd.start) |=> r_done[$past(r_best_idx)])
        else $error("emitted entry not marked");

endmodule

// ----- rtl/shannon_code_builder_top.sv -----
// Channel   Direction  Valid          Stall          Payload
// input     in         i_in_valid     o_in_stall     i_in_item  (t_in_item)
// result    out        o_out_valid    i_out_stall    o_out_item (t_out_item)
//
// Loading accepts one item per cycle; stall rises once the set closes.
// Each result then comes from one pass of the store's single read port,
// which finds the largest unemitted probability.
// Reset is synchronous, active low; the store needs no clearing.
// A stalled result holds in the output register; the next pass still runs,
// and its result waits until the held one is taken.
module shannon_code_builder_top
    import scb_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(MAX_SYMBOLS);

    t_ctrl_cmd     cmd;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] cmp_idx;

    scb_ctrl #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_symbol (i_in_item.last_symbol),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_cmd         (cmd),
        .o_wr_idx      (wr_idx),
        .o_rd_idx      (rd_idx),
        .o_cmp_idx     (cmp_idx)
    );

    scb_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_wr_idx   (wr_idx),
        .i_rd_idx   (rd_idx),
        .i_cmp_idx  (cmp_idx),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

// ----- test/shannon_code_builder_top_test.sv -----
import scb_pkg::*;

class code_table_checker;
    t_in_item  set_items[$];
    t_out_item expected_codes[$];
    int        mismatches;
    int        codes_seen;

    function void note_input(t_in_item it);
        int        order[$];
        int        n;
        int        k;
        int        sum;
        int        unity;
        int        w;
        int        len;
        int        p;
        t_out_item want;
        set_items.push_back(it);
        if (!it.last_symbol && set_items.size() < MAX_SYMBOLS_DEF) begin
            return;
        end
        n = set_items.size();
        unity = 1 << PROB_BITS;
        // stable sort, descending probability
        for (int i = 0; i < n; i++) begin
            k = order.size();
            while (k > 0 && set_items[order[k-1]].probability < set_items[i].probability) begin
                k--;
            end
            order.insert(k, i);
        end
        sum = 0;
        for (int j = 0; j < n; j++) begin
            p = set_items[order[j]].probability;
            want = '0;
            want.out_symbol = set_items[order[j]].symbol;
            want.last_code = (j == n - 1);
            if (p == 0 || sum >= unity) begin
                want.error_flag = 1'b1;
            end else begin
                w = p - 1;
                len = PROB_BITS + 1;
                while (w != 0) begin
                    len--;
                    w = w >> 1;
                end
                want.code_length = LEN_BITS'(len);
                if (len <= PROB_BITS) begin
                    want.code_word = WORD_BITS'(sum >> (PROB_BITS - len));
                end else begin
                    want.code_word = WORD_BITS'(sum << (len - PROB_BITS));
                end
            end
            expected_codes.push_back(want);
            sum = sum + p;
            if (sum > unity) begin
                sum = unity;
            end
        end
        set_items.delete();
    endfunction

    function void check_code(t_out_item got);
        t_out_item want;
        codes_seen++;
        if (expected_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected item: sym=%0d len=%0d word=%h err=%b last=%b",
                         got.out_symbol, got.code_length, got.code_word,
                         got.error_flag, got.last_code);
            end
            return;
        end
        want = expected_codes.pop_front();
        if (got.out_symbol !== want.out_symbol || got.code_length !== want.code_length ||
            got.code_word !== want.code_word || got.error_flag !== want.error_flag ||
            got.last_code !== want.last_code) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp sym=%0d len=%0d word=%h err=%b last=%b",
                         want.out_symbol, want.code_length, want.code_word,
                         want.error_flag, want.last_code);
                $display("          got sym=%0d len=%0d word=%h err=%b last=%b",
                         got.out_symbol, got.code_length, got.code_word,
                         got.error_flag, got.last_code);
            end
        end
    endfunction
endclass

module shannon_code_builder_top_test;
    localparam int LIMIT = 200000;
    localparam int ITEMS = 410;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item out_item;

    code_table_checker codes;
    bit  calm       = 1'b0;
    int  items_sent = 0;
    int  stall_left = 0;
    int  cycles     = 0;

    shannon_code_builder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 12) begin
            return 0;
        end
        if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [7:0] sym, input logic [15:0] prob,
                             input logic last);
        int       gap;
        t_in_item it;
        it.symbol = sym;
        it.probability = prob;
        it.last_symbol = last;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        codes.note_input(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (codes.expected_codes.size() != 0) @(posedge clk);
    endtask

    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (o_out_valid && !out_stall) begin
                codes.check_code(out_item);
            end
            if (!held && codes.codes_seen >= 40) begin
                held = 1'b1;
                hold = 600;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        int   n;
        int   mode;
        int   budget;
        int   share;
        int   base;
        int   p;
        int   set_no;
        logic last;
        codes = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(8'd0, 16'hFFFF, 1'b1);
        send_item(8'd255, 16'd0, 1'b0);
        send_item(8'd1, 16'd1, 1'b1);
        send_item(8'd2, 16'd32768, 1'b0);
        send_item(8'd3, 16'd32768, 1'b0);
        send_item(8'd4, 16'd100, 1'b1);
        send_item(8'd5, 16'd1000, 1'b0);
        send_item(8'd6, 16'd1000, 1'b1);
        for (int k = 0; k < MAX_SYMBOLS_DEF; k++) begin
            send_item(8'(16 + k), 16'((k + 1) * 256), 1'b0);
        end
        wait_drained();

        set_no = 0;
        while (items_sent < ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (set_no == 12) begin
                wait_drained();
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_SYMBOLS_DEF)
                                            : $urandom_range(1, 8);
            mode = $urandom_range(0, 9);
            budget = 1 << PROB_BITS;
            base = (mode == 9) ? (1 << $urandom_range(0, 12))
                               : $urandom_range(1, 65535 / n);
            for (int k = 0; k < n; k++) begin
                if (mode <= 5) begin
                    share = budget / (n - k);
                    if (k == n - 1 && $urandom_range(0, 3) == 0) begin
                        share = budget;
                    end
                    if (share > 65535) begin
                        share = 65535;
                    end
                    p = $urandom_range(1, share);
                    budget = budget - p;
                end else if (mode == 6) begin
                    p = $urandom_range(0, 65535);
                end else if (mode == 7) begin
                    case ($urandom_range(0, 5))
                        0: p = 0;
                        1: p = 1;
                        2: p = 16384;
                        3: p = 32768;
                        4: p = 65535;
                        default: p = $urandom_range(0, 65535);
                    endcase
                end else begin
                    p = base;
                end
                if (k < n - 1) begin
                    last = 1'b0;
                end else if (n == MAX_SYMBOLS_DEF) begin
                    last = $urandom_range(0, 1);
                end else begin
                    last = 1'b1;
                end
                send_item(8'($urandom_range(0, 255)), 16'(p), last);
            end
            set_no++;
        end
        calm = 1'b0;
        wait_drained();
        repeat (400) @(posedge clk);
        if (codes.mismatches == 0 && codes.expected_codes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
